// ----- rtl/mck_pkg.sv -----
// mck_pkg: shared types, constants and tables for the Morse code keyer.
// Holds the character code table and the microcode ROM of the sequencer.
// No dependencies.
`default_nettype none

package mck_pkg;

    localparam int unsigned CodeCount = 59;
    localparam logic [7:0] ElementBits = 8'hFE;
    localparam logic [15:0] UnitReset = 16'd60;
    localparam logic [15:0] ToneReset = 16'd596;
    localparam int unsigned StepBits = 3;

    localparam logic [7:0] CODE_TABLE [0:CodeCount-1] = '{
        8'd0,   8'd0,  8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,   8'd0,  8'd0,   8'd0,  8'd115, 8'd49, 8'd106, 8'd41,
        8'd63,  8'd62, 8'd60,  8'd56, 8'd48, 8'd32, 8'd33, 8'd35,
        8'd39,  8'd47, 8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd76,
        8'd0,   8'd6,  8'd17,  8'd21, 8'd9,  8'd2,  8'd20, 8'd11,
        8'd16,  8'd4,  8'd30,  8'd13, 8'd18, 8'd7,  8'd5,  8'd15,
        8'd22,  8'd27, 8'd10,  8'd8,  8'd3,  8'd12, 8'd24, 8'd14,
        8'd25,  8'd29, 8'd19
    };

    typedef enum logic [1:0] {
        UNITS_ONE   = 2'd0,
        UNITS_TWO   = 2'd1,
        UNITS_THREE = 2'd2,
        UNITS_FOUR  = 2'd3
    } units_t;

    typedef enum logic [1:0] {
        USEL_ONE  = 2'd0,
        USEL_DD   = 2'd1,
        USEL_TWO  = 2'd2,
        USEL_FOUR = 2'd3
    } usel_t;

    typedef enum logic [2:0] {
        COND_NEXT    = 3'd0,
        COND_WAIT_IN = 3'd1,
        COND_SKIP    = 3'd2,
        COND_SPACE   = 3'd3,
        COND_EMPTY   = 3'd4,
        COND_ALWAYS  = 3'd5
    } cond_t;

    typedef logic [StepBits-1:0] step_t;

    typedef struct packed {
        logic  emit;
        logic  tone;
        usel_t usel;
        logic  last;
        logic  shift;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic   tone;
        units_t units;
        logic   last;
    } seg_t;

    localparam step_t StepFetch = 3'd0;
    localparam step_t StepLoop  = 3'd3;
    localparam step_t StepGap   = 3'd6;
    localparam step_t StepWord  = 3'd7;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{emit: 1'b0, tone: 1'b0, usel: USEL_ONE, last: 1'b0, shift: 1'b0,
              cond: COND_NEXT, target: StepFetch};
        case (step)
            3'd0: w.cond = COND_WAIT_IN;
            3'd1: begin
                w.cond = COND_SKIP;
                w.target = StepFetch;
            end
            3'd2: begin
                w.cond = COND_SPACE;
                w.target = StepWord;
            end
            3'd3: begin
                w.cond = COND_EMPTY;
                w.target = StepGap;
            end
            3'd4: begin
                w.emit = 1'b1;
                w.tone = 1'b1;
                w.usel = USEL_DD;
            end
            3'd5: begin
                w.emit = 1'b1;
                w.shift = 1'b1;
                w.cond = COND_ALWAYS;
                w.target = StepLoop;
            end
            3'd6: begin
                w.emit = 1'b1;
                w.usel = USEL_TWO;
                w.last = 1'b1;
                w.cond = COND_ALWAYS;
                w.target = StepFetch;
            end
            3'd7: begin
                w.emit = 1'b1;
                w.usel = USEL_FOUR;
                w.last = 1'b1;
                w.cond = COND_ALWAYS;
                w.target = StepFetch;
            end
            default: w.cond = COND_ALWAYS;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mck_seq.sv -----
// mck_seq: microcoded sequencer that turns one character into segments.
// Step counter, control ROM and code shift register. Depends on mck_pkg.
`default_nettype none

module mck_seq
    import mck_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    output logic            seg_valid,
    input  wire logic       seg_ready,
    output seg_t            seg
);

    step_t      step_reg, step_next;
    logic [7:0] code_reg, code_next;
    logic       skip_reg, skip_next;
    logic       space_reg, space_next;
    uword_t     uw;
    logic [7:0] folded;
    logic [7:0] idx8;
    logic [5:0] idx;
    logic       in_range;
    logic       jump;
    logic       hold;

    assign uw = ucode(step_reg);

    always_comb
    begin
        folded = char_code;
        if (char_code >= 8'h61 && char_code <= 8'h7A)
        begin
            folded = char_code - 8'h20;
        end
        idx8 = folded - 8'h20;
        idx = idx8[5:0];
        in_range = (char_code >= 8'h20) && (folded <= 8'h5A);
    end

    assign in_ready = (uw.cond == COND_WAIT_IN);
    assign seg_valid = uw.emit;
    assign hold = (uw.emit && !seg_ready) || (in_ready && !in_valid);

    always_comb
    begin
        case (uw.cond)
            COND_SKIP:   jump = skip_reg;
            COND_SPACE:  jump = space_reg;
            COND_EMPTY:  jump = ((code_reg & ElementBits) == 8'h00);
            COND_ALWAYS: jump = 1'b1;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        seg.tone = uw.tone;
        seg.last = uw.last;
        case (uw.usel)
            USEL_DD:   seg.units = code_reg[0] ? UNITS_THREE : UNITS_ONE;
            USEL_TWO:  seg.units = UNITS_TWO;
            USEL_FOUR: seg.units = UNITS_FOUR;
            default:   seg.units = UNITS_ONE;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        code_next = code_reg;
        skip_next = skip_reg;
        space_next = space_reg;
        if (!hold)
        begin
            step_next = jump ? uw.target : step_reg + step_t'(1);
            if (uw.shift)
            begin
                code_next = {1'b0, code_reg[7:1]};
            end
        end
        if (in_ready && in_valid)
        begin
            skip_next = !in_range;
            space_next = (idx == 6'd0);
            code_next = in_range ? CODE_TABLE[idx] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= StepFetch;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        skip_reg <= skip_next;
        space_reg <= space_next;
    end

endmodule

`default_nettype wire

// ----- rtl/morse_code_keyer.sv -----
// morse_code_keyer: top level with APB registers, sequencer and output register.
// Depends on mck_pkg and mck_seq.
//
// Takes one character byte per word and sends it as timed segments, one segment per
// output word. Each byte is checked for skip, space and empty code; a dot or dash is
// a tone segment and a one-unit space, a two-unit gap ends the character, and a space
// gives a four-unit word gap. The step counter runs one control word per cycle, holding
// when the output register is full or no byte is offered. Bytes below space or above 'Z'
// after case folding give no output. Registers: unit_length at 0x0, tone_divisor at 0x4.
`default_nettype none

module morse_code_keyer
    import mck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tone_on,
    output logic [17:0]      duration,
    output logic [15:0]      pitch_divisor,
    output logic             last_segment
);

    logic [15:0] unit_reg;
    logic [15:0] tone_reg;
    logic        out_valid_reg, out_valid_next;
    logic        tone_on_reg;
    logic [17:0] duration_reg, duration_next;
    logic [15:0] pitch_reg;
    logic        last_reg;
    logic        seg_valid;
    logic        seg_ready;
    seg_t        seg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign prdata = {16'h0000, paddr[2] ? tone_reg : unit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UnitReset;
            tone_reg <= ToneReset;
        end
        else if (wr_en)
        begin
            if (paddr[2])
            begin
                tone_reg <= pwdata[15:0];
            end
            else
            begin
                unit_reg <= pwdata[15:0];
            end
        end
    end

    mck_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    assign seg_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        case (seg.units)
            UNITS_TWO:   duration_next = {1'b0, unit_reg, 1'b0};
            UNITS_THREE: duration_next = {1'b0, unit_reg, 1'b0} + {2'b00, unit_reg};
            UNITS_FOUR:  duration_next = {unit_reg, 2'b00};
            default:     duration_next = {2'b00, unit_reg};
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seg_valid && seg_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_valid && seg_ready)
        begin
            tone_on_reg <= seg.tone;
            duration_reg <= duration_next;
            pitch_reg <= seg.tone ? tone_reg : 16'h0000;
            last_reg <= seg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign tone_on = tone_on_reg;
    assign duration = duration_reg;
    assign pitch_divisor = pitch_reg;
    assign last_segment = last_reg;

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |=> out_valid)
        else $error("emitted segment not presented");

    a_accept_once: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    a_no_emit_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !seg_valid)
        else $error("segment emitted while waiting for input");

endmodule

`default_nettype wire

// ----- tb/morse_segment_checker.sv -----
// morse_segment_checker: watches the register port and both word channels of the
// Morse keyer, predicts the timed segments of each character and compares them.
// Depends on mck_pkg for the register reset values.
`timescale 1ns / 1ps

module morse_segment_checker
    import mck_pkg::*;
#(
    parameter logic [2:0] UNIT_ADDR = 3'h0,
    parameter logic [2:0] TONE_ADDR = 3'h4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        tone_on,
    input  logic [17:0] duration,
    input  logic [15:0] pitch_divisor,
    input  logic        last_segment,
    output int          errors,
    output int          outstanding,
    output int          keyed,
    output int          segments
);

    localparam int          CODE_ENTRIES = 59;
    localparam logic [7:0]  ASCII_SPACE  = 8'h20;
    localparam logic [7:0]  LOWER_A      = 8'h61;
    localparam logic [7:0]  LOWER_Z      = 8'h7A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;
    localparam logic [7:0]  ELEMENT_MASK = 8'hFE;
    localparam int unsigned DOT_UNITS    = 1;
    localparam int unsigned DASH_UNITS   = 3;
    localparam int unsigned SPACE_UNITS  = 1;
    localparam int unsigned LETTER_GAP   = 2;
    localparam int unsigned WORD_GAP     = 4;

    // elements LSB first, 1 = dash, above a marker bit; space through 'Z'
    localparam logic [7:0] MORSE_CODES [0:CODE_ENTRIES-1] = '{
        8'd0,  8'd0,  8'd0,   8'd0,  8'd0,  8'd0,  8'd0,   8'd0,
        8'd0,  8'd0,  8'd0,   8'd0,  8'd115, 8'd49, 8'd106, 8'd41,
        8'd63, 8'd62, 8'd60,  8'd56, 8'd48, 8'd32, 8'd33,  8'd35,
        8'd39, 8'd47, 8'd0,   8'd0,  8'd0,  8'd0,  8'd0,   8'd76,
        8'd0,  8'd6,  8'd17,  8'd21, 8'd9,  8'd2,  8'd20,  8'd11,
        8'd16, 8'd4,  8'd30,  8'd13, 8'd18, 8'd7,  8'd5,   8'd15,
        8'd22, 8'd27, 8'd10,  8'd8,  8'd3,  8'd12, 8'd24,  8'd14,
        8'd25, 8'd29, 8'd19
    };

    typedef struct packed {
        logic        tone;
        logic [17:0] ticks;
        logic [15:0] pitch;
        logic        last;
    } segment_t;

    segment_t    segment_q[$];
    logic [15:0] unit_len = UnitReset;
    logic [15:0] tone_div = ToneReset;
    int          n_fail   = 0;
    int          n_keyed  = 0;
    int          n_seg    = 0;

    function automatic segment_t make_segment(input logic tone, input int unsigned units,
                                              input logic last);
        segment_t    s;
        int unsigned ticks;
        ticks   = unit_len * units;
        s.tone  = tone;
        s.ticks = ticks[17:0];
        s.pitch = tone ? tone_div : 16'd0;
        s.last  = last;
        return s;
    endfunction

    task automatic key_character(input logic [7:0] ch);
        logic [7:0] idx;
        logic [7:0] code;
        if (ch < ASCII_SPACE)
            return;
        idx = ch;
        if (ch >= LOWER_A && ch <= LOWER_Z)
            idx = ch - CASE_OFFSET;
        idx = idx - ASCII_SPACE;
        if (idx >= CODE_ENTRIES)
            return;
        if (idx == 0)
        begin
            segment_q.push_back(make_segment(1'b0, WORD_GAP, 1'b1));
            return;
        end
        code = MORSE_CODES[idx];
        while ((code & ELEMENT_MASK) != 0)
        begin
            segment_q.push_back(make_segment(1'b1, code[0] ? DASH_UNITS : DOT_UNITS, 1'b0));
            segment_q.push_back(make_segment(1'b0, SPACE_UNITS, 1'b0));
            code = code >> 1;
        end
        segment_q.push_back(make_segment(1'b0, LETTER_GAP, 1'b1));
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        n_fail++;
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        segment_t exp_seg;
        int       depth;
        if (!rst_n)
        begin
            unit_len = UnitReset;
            tone_div = ToneReset;
            segment_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == UNIT_ADDR)
                    unit_len = pwdata[15:0];
                else if (paddr == TONE_ADDR)
                    tone_div = pwdata[15:0];
            end
            if (out_valid && out_ready)
            begin
                n_seg++;
                if (segment_q.size() == 0)
                begin
                    n_fail++;
                    $display("%0t unexpected segment: expected none, actual tone %0b %0d ticks",
                             $time, tone_on, duration);
                end
                else
                begin
                    exp_seg = segment_q.pop_front();
                    if (tone_on !== exp_seg.tone)
                        note_mismatch("tone_on", exp_seg.tone, tone_on);
                    if (duration !== exp_seg.ticks)
                        note_mismatch("duration", exp_seg.ticks, duration);
                    if (pitch_divisor !== exp_seg.pitch)
                        note_mismatch("pitch_divisor", exp_seg.pitch, pitch_divisor);
                    if (last_segment !== exp_seg.last)
                        note_mismatch("last_segment", exp_seg.last, last_segment);
                end
            end
            if (in_valid && in_ready)
            begin
                depth = segment_q.size();
                key_character(char_code);
                if (segment_q.size() > depth)
                    n_keyed++;
            end
        end
        errors      <= n_fail;
        outstanding <= segment_q.size();
        keyed       <= n_keyed;
        segments    <= n_seg;
    end

endmodule

// ----- tb/tb.sv -----
// tb: top of the Morse keyer testbench; clock, reset, register writes, character
// stimulus and segment back-pressure, with the verdict taken from the checker.
// Depends on morse_code_keyer (and mck_pkg) and morse_segment_checker.
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] REG_UNIT_LENGTH  = 3'h0;
    localparam logic [2:0] REG_TONE_DIVISOR = 3'h4;
    localparam int unsigned STALL_MAX       = 5;
    localparam int          SETTLE_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          PHASES          = 5;
    localparam int          WORDS_PER_PHASE = 45;

    // extremes, both cases, dots, dashes, longest codes, space, empty codes, ignored bytes
    localparam logic [7:0] DIRECTED [0:21] = '{
        8'h20, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h5B,
        8'h60, 8'h7B, 8'h30, 8'h2C, 8'h3F, 8'h2E, 8'h21, 8'h40, 8'h45, 8'h54, 8'h2D
    };
    localparam logic [7:0] ZERO_UNIT_CHARS [0:3] = '{8'h20, 8'h45, 8'h54, 8'h21};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  char_code = '0;
    logic        out_ready = 1'b0;
    logic        tx_eager  = 1'b0;
    logic        rx_eager  = 1'b0;

    logic [31:0] prdata;
    logic        pready;
    logic        in_ready;
    logic        out_valid;
    logic        tone_on;
    logic [17:0] duration;
    logic [15:0] pitch_divisor;
    logic        last_segment;

    int          errors;
    int          outstanding;
    int          keyed;
    int          segments;
    int          quiet_cycles = 0;
    int unsigned rx_hold      = 0;
    int unsigned rx_draw;

    always #6 clk = ~clk;

    morse_code_keyer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tone_on       (tone_on),
        .duration      (duration),
        .pitch_divisor (pitch_divisor),
        .last_segment  (last_segment)
    );

    morse_segment_checker #(
        .UNIT_ADDR (REG_UNIT_LENGTH),
        .TONE_ADDR (REG_TONE_DIVISOR)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tone_on       (tone_on),
        .duration      (duration),
        .pitch_divisor (pitch_divisor),
        .last_segment  (last_segment),
        .errors        (errors),
        .outstanding   (outstanding),
        .keyed         (keyed),
        .segments      (segments)
    );

    // segment sink: random stall after each accepted word, none when rx_eager is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else if (out_valid && out_ready)
        begin
            rx_draw = rx_eager ? 0 : $urandom_range(0, STALL_MAX);
            rx_hold   <= rx_draw;
            out_ready <= (rx_draw == 0);
        end
        else if (rx_hold > 1)
            rx_hold <= rx_hold - 1;
        else
        begin
            rx_hold   <= 0;
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no progress for %0d cycles, %0d segments pending",
                         $time, quiet_cycles, outstanding);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold off until every predicted segment is out and the sequencer is idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(8'h20, 8'h5A));
        if (r < 80)
            return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int          base;
        logic [15:0] unit_val;
        logic [15:0] tone_val;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_char(DIRECTED[i]);
        drain();

        reg_write(REG_UNIT_LENGTH, 16'd0);
        foreach (ZERO_UNIT_CHARS[i])
            send_char(ZERO_UNIT_CHARS[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    unit_val = 16'd1;
                    tone_val = 16'hFFFF;
                end
                1:
                begin
                    unit_val = 16'hFFFF;
                    tone_val = 16'd1;
                end
                3:
                begin
                    unit_val = 16'($urandom_range(1, 16));
                    tone_val = 16'($urandom_range(1, 65535));
                end
                default:
                begin
                    unit_val = 16'($urandom_range(1, 65535));
                    tone_val = 16'($urandom_range(1, 65535));
                end
            endcase
            reg_write(REG_UNIT_LENGTH, unit_val);
            reg_write(REG_TONE_DIVISOR, tone_val);
            tx_eager <= (p == 0) || ($urandom_range(0, 3) == 0);
            rx_eager <= (p == 0) || ($urandom_range(0, 3) == 0);
            base = keyed;
            while (keyed - base < WORDS_PER_PHASE)
                send_char(pick_char());
            drain();
        end

        $display("keyed %0d characters into %0d segments", keyed, segments);
        $display("register settings: reset values, zero unit, both extremes, %0d random",
                 PHASES - 2);
        if (errors == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mck_pkg.sv
rtl/mck_seq.sv
rtl/morse_code_keyer.sv
tb/morse_segment_checker.sv
tb/tb.sv
